// File: hw/rtl/lkvc_pkg.sv
// Shared request, response and cell control types for the LRU key-value cache.
package lkvc_pkg;

    localparam int unsigned CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } rsp_t;

    // Per-cell control: capture registers the key compare, shift takes the neighbor's entry.
    typedef struct packed {
        logic capture;
        logic shift;
    } cell_ctl_t;

endpackage

// File: hw/rtl/lkvc_cell.sv
// One position of the recency chain: holds an entry, compares it and shifts from its neighbor.
module lkvc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lkvc_pkg::cell_ctl_t ctl,
    input  logic signed [31:0] req_key,
    input  logic signed [31:0] prev_key,
    input  logic signed [31:0] prev_value,
    input  logic               prev_valid,
    input  logic               below_in,
    output logic signed [31:0] key,
    output logic signed [31:0] value,
    output logic               valid,
    output logic               match,
    output logic               below_out
);
    import lkvc_pkg::*;

    logic signed [31:0] key_reg;
    logic signed [31:0] value_reg;
    logic               valid_reg;
    logic               match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                match_reg <= valid_reg && (key_reg == req_key);
            end
            if (ctl.shift)
            begin
                valid_reg <= prev_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign key       = key_reg;
    assign value     = value_reg;
    assign valid     = valid_reg;
    assign match     = match_reg;
    assign below_out = match_reg | below_in;

endmodule

// File: hw/rtl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: request/response channels, chain of cells, control.
//
// Usage: a request (op, key, value) is offered on in_valid/in_data and taken when in_ready
// is high. A get looks the key up; a put stores key and value as the most recent entry,
// evicting the least recent entry when the store is full and the key is new. Every request
// produces exactly one response (hit, read_value) on out_valid/out_data.
// The capacity register is written through cfg_valid/cfg_data; cfg_ready is always high.
// Write it only while no request is in flight.
// Operation: in IDLE the request is taken and every cell
// compares its key with the request key and registers the match; in UPDATE the chain
// shifts and the response is loaded into the output register, once that register is free.
// A new request is taken only back in IDLE, so the cache cannot take a new request before
// the previous one has been applied to the chain.
// Reset clears all valid bits, the fill count and the output valid bit, and sets the
// capacity to 16. Entry keys and values are not reset.
// When the receiver stalls, the response waits in the output register; one further request
// may be taken and compared, and its update is held until the output register is free.
module lru_key_value_cache_top #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lkvc_pkg::req_t               in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lkvc_pkg::rsp_t               out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data
);
    import lkvc_pkg::*;

    localparam int unsigned FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    // One-hot control: IDLE takes a request and captures the compare, UPDATE applies it.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0]  capacity_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    req_t              req_reg;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    // Chain wiring; index 0 is the most recent position.
    logic signed [31:0] cell_key   [MAX_ENTRIES];
    logic signed [31:0] cell_value [MAX_ENTRIES];
    logic               cell_valid [MAX_ENTRIES];
    logic               cell_match [MAX_ENTRIES];
    logic               below      [MAX_ENTRIES+1];
    cell_ctl_t          cell_ctl   [MAX_ENTRIES];

    logic               accept;
    logic               do_update;
    logic               hit_any;
    logic signed [31:0] hit_value;
    logic signed [31:0] head_value;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   fill_ext;
    logic [CMP_W-1:0]   limit;
    logic               full;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign do_update = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);

    // The chain holds unique keys, so at most one cell matches and an OR picks its value.
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    assign hit_any    = below[0];
    assign head_value = (req_reg.op == OP_PUT) ? req_reg.value : hit_value;

    // Capacity out of range is clamped: zero acts as one, above the depth acts as the depth.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(capacity_reg);
        end
    end

    assign fill_ext = CMP_W'(fill_reg);
    assign full     = (fill_ext >= cap_eff);
    // On a put of a new key, cells up to and including this limit take their neighbor's entry.
    assign limit    = full ? (fill_ext - CMP_W'(1)) : fill_ext;

    assign below[MAX_ENTRIES] = 1'b0;

    generate
        for (genvar i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            logic signed [31:0] prev_key;
            logic signed [31:0] prev_value;
            logic               prev_valid;
            logic               shift_sel;

            if (i == 0)
            begin : g_head
                assign prev_key   = req_reg.key;
                assign prev_value = head_value;
                assign prev_valid = 1'b1;
                assign shift_sel  = hit_any || (req_reg.op == OP_PUT);
            end
            else
            begin : g_body
                assign prev_key   = cell_key[i-1];
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                // On a hit, every cell down to the matching one moves one place.
                assign shift_sel  = hit_any ? below[i]
                                  : ((req_reg.op == OP_PUT) && (CMP_W'(i) <= limit));
            end

            assign cell_ctl[i] = '{capture: accept, shift: (do_update && shift_sel)};

            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl[i]),
                .req_key    (in_data.key),
                .prev_key   (prev_key),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .below_in   (below[i+1]),
                .key        (cell_key[i]),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .match      (cell_match[i]),
                .below_out  (below[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (do_update)
                begin
                    state_next               = ST_IDLE;
                    out_valid_next           = 1'b1;
                    out_data_next.hit        = hit_any;
                    out_data_next.read_value = (!hit_any || (req_reg.op == OP_PUT))
                                             ? '0 : hit_value;
                    if (!hit_any && (req_reg.op == OP_PUT) && !full)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            req_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LRU key-value cache top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    // Number of entries in the design under test, and the run's safety limit in cycles.
    localparam int NENT      = 16;
    localparam int LIMIT     = 200000;
    localparam int IDLE_PCT  = 19;
    localparam int CHUNK     = 95;
    localparam int NCHUNKS   = 10;
    localparam int STALL_LEN = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Every input of the block starts at a known value.
    logic                in_valid = 1'b0;
    logic                in_ready;
    req_t                in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rsp_t                out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data = '0;

    lru_key_value_cache_top #(
        .MAX_ENTRIES (NENT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Requests waiting to be offered, and the responses the cache owes us, oldest first.
    req_t req_backlog[$];
    rsp_t expected_rsp[$];
    int   reqs_queued = 0;
    int   reqs_taken = 0;
    int   bad_count = 0;
    logic req_taken = 1'b0;

    // When set, neither side idles; used for one stretch of back-to-back traffic.
    logic quiet = 1'b0;

    // The receiver serves one long hold-off each time stall_asked moves ahead.
    int stall_asked = 0;
    int stall_served = 0;
    int stall_left = 0;

    // Our own picture of the cache: position 0 is the most recently used entry.
    logic signed [31:0] lru_key[NENT];
    logic signed [31:0] lru_val[NENT];
    int                 lru_fill = 0;
    logic [CAP_W-1:0]   cap_reg = CAP_RESET;

    // Keys that the random requests keep coming back to, so that hits and evictions happen.
    logic signed [31:0] key_pool[24];

    // Applies one request to the cache picture and returns the response it must produce.
    function automatic rsp_t cache_lookup_update(input req_t r);
        rsp_t               res;
        logic               found;
        int                 pos;
        int                 eff;
        logic signed [31:0] stored;
        found = 1'b0;
        pos = 0;
        for (int i = 0; i < lru_fill; i++)
        begin
            if (!found && lru_key[i] == r.key)
            begin
                found = 1'b1;
                pos = i;
            end
        end
        res.hit = found;
        res.read_value = '0;
        if (found)
        begin
            stored = lru_val[pos];
            if (r.op == OP_GET)
                res.read_value = stored;
            for (int i = pos; i > 0; i--)
            begin
                lru_key[i] = lru_key[i-1];
                lru_val[i] = lru_val[i-1];
            end
            lru_key[0] = r.key;
            lru_val[0] = (r.op == OP_GET) ? stored : r.value;
        end
        else if (r.op == OP_PUT)
        begin
            // A capacity of zero behaves as one, anything past the entry count as full size.
            eff = (cap_reg == 0) ? 1 : ((cap_reg > NENT) ? NENT : int'(cap_reg));
            if (lru_fill >= eff)
            begin
                // Store is full (or over a lowered capacity): the least recent entry drops off
                // the end, so the fill count stays where it is.
                for (int i = lru_fill - 1; i > 0; i--)
                begin
                    lru_key[i] = lru_key[i-1];
                    lru_val[i] = lru_val[i-1];
                end
            end
            else
            begin
                for (int i = lru_fill; i > 0; i--)
                begin
                    lru_key[i] = lru_key[i-1];
                    lru_val[i] = lru_val[i-1];
                end
                lru_fill++;
            end
            lru_key[0] = r.key;
            lru_val[0] = r.value;
        end
        return res;
    endfunction

    function automatic void queue_req(input logic op, input logic [31:0] k, input logic [31:0] v);
        req_t r;
        r.op = op;
        r.key = k;
        r.value = v;
        req_backlog.push_back(r);
        reqs_queued++;
    endfunction

    // Mostly keys from a window of the pool, sometimes a fresh key; values lean on the extremes.
    function automatic req_t random_req(input int span);
        req_t r;
        r.op = ($urandom_range(1) == 1) ? OP_PUT : OP_GET;
        if ($urandom_range(99) < 85)
            r.key = key_pool[$urandom_range(span - 1)];
        else
            r.key = $urandom;
        case ($urandom_range(19))
            0: r.value = 32'h7FFF_FFFF;
            1: r.value = 32'h8000_0000;
            2: r.value = '1;
            3: r.value = '0;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    // Sender: holds a request until it is taken, then offers the next one or idles.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_taken)
        begin
            if (req_backlog.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                in_data  <= req_backlog.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for. The
    // hold-off is counted here so that the sender keeps pushing and the cache has to stall.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_asked != stall_served)
        begin
            stall_served = stall_asked;
            stall_left = STALL_LEN;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: every accepted request feeds the cache picture, every accepted response is
    // checked against the oldest expectation. Everything is sampled at the rising edge.
    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                expected_rsp.push_back(cache_lookup_update(in_data));
                reqs_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("response with no request pending: hit %0b value %0d",
                                 out_data.hit, out_data.read_value);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (out_data.hit !== want.hit || out_data.read_value !== want.read_value)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("expected hit %0b value %0d, got hit %0b value %0d",
                                     want.hit, want.read_value, out_data.hit,
                                     out_data.read_value);
                    end
                end
            end
        end
    end

    // Waits until every request has been taken and answered, then lets the pipeline
    // settle before anything else happens.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (reqs_taken != reqs_queued || expected_rsp.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // The capacity register is only written while the cache is idle.
    task automatic set_capacity(input logic [CAP_W-1:0] c);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_reg = c;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Watchdog: a cycle counter that ends a hung run.
    initial
    begin
        int cyc;
        cyc = 0;
        while (cyc < LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("lru_key_value_cache_top regression: fail");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] cap_plan[NCHUNKS];
        int               span;
        key_pool[0] = 32'h7FFF_FFFF;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = '1;
        key_pool[3] = '0;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;

        // The first setting lowers the capacity below a full store; the others take in zero,
        // the top of the field, one, just past the entry count and a random pick.
        cap_plan = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd0, 5'd16, 5'd5};
        cap_plan[7] = $urandom_range(31);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity: a lookup in an empty store, the key and value
        // extremes, an update of a present key, a miss, and then enough new keys to fill the
        // store and push out the least recent entry.
        queue_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
        queue_req(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_req(OP_GET, 32'hFFFF_FFFF, 32'h0);
        queue_req(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_req(OP_PUT, 32'hFFFF_FFFF, 32'h5);
        queue_req(OP_GET, 32'h0000_3039, 32'h0);
        queue_req(OP_GET, 32'hFFFF_FFFF, 32'h0);
        queue_req(OP_GET, 32'h7FFF_FFFF, 32'h0);
        for (int k = 1; k <= 12; k++)
            queue_req(OP_PUT, k, k * 3);
        queue_req(OP_PUT, 32'd200, 32'hDEAD_BEEF);
        queue_req(OP_GET, 32'h0000_0000, 32'h0);
        wait_drained();

        // Random part in chunks, each under its own capacity. Between chunks the sender
        // pauses until every response is back, which is also when the register may change.
        for (int c = 0; c < NCHUNKS; c++)
        begin
            set_capacity(cap_plan[c]);
            span = $urandom_range(4, 24);
            if (c == 8)
                quiet = 1'b1;
            for (int n = 0; n < CHUNK; n++)
                req_backlog.push_back(random_req(span));
            reqs_queued += CHUNK;
            // Long receiver hold-off while a full chunk is still being offered.
            if (c == 5)
                stall_asked++;
            wait_drained();
            quiet = 1'b0;
        end

        if (bad_count == 0)
            $display("lru_key_value_cache_top regression: pass");
        else
            $display("lru_key_value_cache_top regression: fail");
        $finish;
    end

endmodule
